### hw/rtl/pulse_frequency_averager_defines.svh
// assertion macros shared by the rtl files
`ifndef PULSE_FREQUENCY_AVERAGER_DEFINES_SVH
`define PULSE_FREQUENCY_AVERAGER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define PFA_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`else

`define PFA_ASSERT_IMP(label, clk, rst_n, a, b)
`define PFA_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

### hw/rtl/pfa_pkg.sv
package pfa_pkg;

    localparam int WIDTH_BITS   = 20;
    localparam int CNT_BITS     = 16;
    localparam int LIMIT_BITS   = 20;
    localparam int SUM_BITS     = 35;
    localparam int FREQ_BITS    = 19;
    localparam int STATUS_BITS  = 2;
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;

    localparam int DIVISOR_BITS = (WIDTH_BITS > CNT_BITS) ? WIDTH_BITS : CNT_BITS;
    localparam int CMP_BITS     = (WIDTH_BITS > LIMIT_BITS) ? WIDTH_BITS : LIMIT_BITS;
    localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

    localparam logic [FREQ_BITS-1:0] RATE_NUMERATOR = FREQ_BITS'(500000);
    localparam logic [STEP_BITS-1:0] RATE_STEPS     = STEP_BITS'(FREQ_BITS);
    localparam logic [STEP_BITS-1:0] AVG_STEPS      = STEP_BITS'(SUM_BITS);

    localparam logic [CNT_BITS-1:0]   SAMPLE_COUNT_RESET  = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0]   TIMEOUT_LIMIT_RESET = CNT_BITS'(10);
    localparam logic [LIMIT_BITS-1:0] WAIT_LIMIT_RESET    = {LIMIT_BITS{1'b1}};

    // register indexes
    localparam logic [1:0] REG_SAMPLE_COUNT  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd1;
    localparam logic [1:0] REG_WAIT_LIMIT    = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ABORT = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [CNT_BITS-1:0]   sample_count;
        logic [CNT_BITS-1:0]   timeout_limit;
        logic [LIMIT_BITS-1:0] pulse_wait_limit;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [STEP_BITS-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

### hw/rtl/pfa_regs.sv
module pfa_regs
    import pfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count     <= SAMPLE_COUNT_RESET;
            cfg_reg.timeout_limit    <= TIMEOUT_LIMIT_RESET;
            cfg_reg.pulse_wait_limit <= WAIT_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAMPLE_COUNT:  cfg_reg.sample_count     <= pwdata[CNT_BITS-1:0];
                REG_TIMEOUT_LIMIT: cfg_reg.timeout_limit    <= pwdata[CNT_BITS-1:0];
                REG_WAIT_LIMIT:    cfg_reg.pulse_wait_limit <= pwdata[LIMIT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAMPLE_COUNT:  prdata = PDATA_BITS'(cfg_reg.sample_count);
            REG_TIMEOUT_LIMIT: prdata = PDATA_BITS'(cfg_reg.timeout_limit);
            REG_WAIT_LIMIT:    prdata = PDATA_BITS'(cfg_reg.pulse_wait_limit);
            default:           prdata = '0;
        endcase
    end

endmodule

### hw/rtl/pfa_divider.sv
`include "pulse_frequency_averager_defines.svh"

module pfa_divider
    import pfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_req_t                req,
    input  logic [SUM_BITS-1:0]     dividend,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output div_rsp_t                rsp,
    output logic [SUM_BITS-1:0]     quotient
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_BITS-1:0]    cnt_reg;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [SUM_BITS-1:0]     quo_reg;
    logic [DIVISOR_BITS-1:0] div_reg;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   shifted;

    // restoring division, one quotient bit per cycle; a short dividend is
    // loaded left-aligned so only its own bits are iterated
    assign shifted = {rem_reg, quo_reg[SUM_BITS-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= (req.steps != '0);
                done_reg <= (req.steps == '0);
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVISOR_BITS])
            begin
                rem_reg <= trial[DIVISOR_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIVISOR_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

    `PFA_ASSERT_IMP(a_no_start_busy, clk, rst_n, req.start, !busy_reg)
    `PFA_ASSERT_NEXT(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `PFA_ASSERT_IMP(a_not_both, clk, rst_n, busy_reg, !done_reg)

endmodule

### hw/rtl/pulse_frequency_averager.sv
// pulse frequency averager
// pulse_width items arrive on a valid/ready channel; each good width w
// (nonzero and not above pulse_wait_limit) adds floor(500000 / w) to a
// running sum, other widths count as timeouts. after sample_count samples
// the block emits frequency = sum / good samples with status 0, or 0 with
// status 2 when no sample was good; when timeouts exceed timeout_limit the
// measurement aborts with frequency 0 and status 1.
// one shared restoring divider does all division, one bit per cycle: a good
// item runs the rate division and then the check before the next ready, a
// timed-out item goes straight to the check; an item that completes a
// measurement adds the average division and the load of the output
// register.
// in_ready is high only while the sequencer idles; the result sits in an
// output register, so the next item is taken while it waits. if a new result
// is ready while the old one is not yet taken, the sequencer holds until
// out_ready frees the slot.
// reset loads the register defaults (sample_count 1, timeout_limit 10,
// pulse_wait_limit all ones) and clears the measurement and output valid.
// registers sit at byte addresses 0, 4 and 8 of the apb port; pready is
// always high.
`include "pulse_frequency_averager_defines.svh"

module pulse_frequency_averager
    import pfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready,
    input  logic [WIDTH_BITS-1:0]  pulse_width,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic [FREQ_BITS-1:0]   frequency,
    output logic [STATUS_BITS-1:0] status,
    output logic                   out_valid,
    input  logic                   out_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_CHECK,
        S_AVG,
        S_EMIT
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic [SUM_BITS-1:0]     div_dividend;
    logic [DIVISOR_BITS-1:0] div_divisor;
    logic [SUM_BITS-1:0]     div_quotient;

    state_t                 state_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [CNT_BITS-1:0]    taken_reg;
    logic [CNT_BITS-1:0]    good_reg;
    logic [CNT_BITS-1:0]    tmo_reg;
    logic [FREQ_BITS-1:0]   res_freq_reg;
    logic [STATUS_BITS-1:0] res_status_reg;
    logic                   out_valid_reg;
    logic [FREQ_BITS-1:0]   out_freq_reg;
    logic [STATUS_BITS-1:0] out_status_reg;

    logic                   in_fire;
    logic                   width_good;
    logic [CNT_BITS-1:0]    target;
    logic                   slot_free;

    pfa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pfa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign width_good = (pulse_width != '0) &&
                        (CMP_BITS'(pulse_width) <= CMP_BITS'(cfg.pulse_wait_limit));
    assign target     = (cfg.sample_count == '0) ? CNT_BITS'(1) : cfg.sample_count;
    assign slot_free  = !out_valid_reg || out_ready;

    // divider launch: rate on a good item, average on completion
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.steps = RATE_STEPS;
        div_dividend  = {RATE_NUMERATOR, {(SUM_BITS-FREQ_BITS){1'b0}}};
        div_divisor   = DIVISOR_BITS'(pulse_width);
        if (state_reg == S_IDLE)
        begin
            div_req.start = in_fire && width_good;
        end
        else if (state_reg == S_CHECK)
        begin
            div_req.steps = AVG_STEPS;
            div_dividend  = sum_reg;
            div_divisor   = DIVISOR_BITS'(good_reg);
            div_req.start = (tmo_reg <= cfg.timeout_limit) && (taken_reg >= target) &&
                            (good_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sum_reg        <= '0;
            taken_reg      <= '0;
            good_reg       <= '0;
            tmo_reg        <= '0;
            out_valid_reg  <= 1'b0;
            res_freq_reg   <= '0;
            res_status_reg <= STATUS_DONE;
            out_freq_reg   <= '0;
            out_status_reg <= STATUS_DONE;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (width_good)
                        begin
                            state_reg <= S_RATE;
                        end
                        else
                        begin
                            tmo_reg   <= tmo_reg + 1'b1;
                            taken_reg <= taken_reg + 1'b1;
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_RATE:
                begin
                    if (div_rsp.done)
                    begin
                        sum_reg   <= sum_reg + SUM_BITS'(div_quotient[FREQ_BITS-1:0]);
                        good_reg  <= good_reg + 1'b1;
                        taken_reg <= taken_reg + 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    priority if (tmo_reg > cfg.timeout_limit)
                    begin
                        res_freq_reg   <= '0;
                        res_status_reg <= STATUS_ABORT;
                        state_reg      <= S_EMIT;
                    end
                    else if (taken_reg >= target)
                    begin
                        if (good_reg == '0)
                        begin
                            res_freq_reg   <= '0;
                            res_status_reg <= STATUS_EMPTY;
                            state_reg      <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_AVG;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_AVG:
                begin
                    if (div_rsp.done)
                    begin
                        res_freq_reg   <= div_quotient[FREQ_BITS-1:0];
                        res_status_reg <= STATUS_DONE;
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // measurement is cleared once the result goes out
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_freq_reg   <= res_freq_reg;
                        out_status_reg <= res_status_reg;
                        sum_reg        <= '0;
                        taken_reg      <= '0;
                        good_reg       <= '0;
                        tmo_reg        <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign frequency = out_freq_reg;
    assign status    = out_status_reg;

    `PFA_ASSERT_IMP(a_div_done_state, clk, rst_n, div_rsp.done,
        (state_reg == S_RATE) || (state_reg == S_AVG))
    `PFA_ASSERT_IMP(a_fault_zero, clk, rst_n, out_valid_reg && (out_status_reg != STATUS_DONE),
        out_freq_reg == '0)
    `PFA_ASSERT_IMP(a_div_idle_at_accept, clk, rst_n, in_fire, !div_rsp.busy)

endmodule

### tb/pulse_freq_checker.sv
module pulse_freq_checker
    import pfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    input  logic [PDATA_BITS-1:0]  prdata,
    input  logic                   pready,
    input  logic [WIDTH_BITS-1:0]  pulse_width,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [FREQ_BITS-1:0]   frequency,
    input  logic [STATUS_BITS-1:0] status,
    input  logic                   out_valid,
    input  logic                   out_ready,
    output int                     error_count,
    output int                     results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FREQ_BITS-1:0]   frequency;
        logic [STATUS_BITS-1:0] status;
    } freq_result_t;

    cfg_t                  cfg;
    logic [SUM_BITS-1:0]   rate_sum;
    logic [CNT_BITS-1:0]   taken_count;
    logic [CNT_BITS-1:0]   good_count;
    logic [CNT_BITS-1:0]   timeout_count;
    freq_result_t          owed_results[$];
    freq_result_t          head;
    logic [1:0]            reg_index;
    logic [PDATA_BITS-1:0] reg_value;
    logic [PDATA_BITS-1:0] reg_mask;
    string                 reg_name;

    task automatic close_measurement(input logic [FREQ_BITS-1:0] f,
                                     input logic [STATUS_BITS-1:0] s);
        freq_result_t r;
        r.frequency = f;
        r.status = s;
        owed_results.push_back(r);
        rate_sum = '0;
        taken_count = '0;
        good_count = '0;
        timeout_count = '0;
    endtask

    task automatic accumulate_pulse(input logic [WIDTH_BITS-1:0] w);
        logic [CNT_BITS-1:0] target;
        logic [63:0]         average;
        target = (cfg.sample_count == '0) ? CNT_BITS'(1) : cfg.sample_count;
        if (w != '0 && 32'(w) <= 32'(cfg.pulse_wait_limit))
        begin
            rate_sum = rate_sum + SUM_BITS'(64'(RATE_NUMERATOR) / 64'(w));
            good_count = good_count + 1'b1;
        end
        else
        begin
            timeout_count = timeout_count + 1'b1;
        end
        taken_count = taken_count + 1'b1;
        // abort wins over completion on the last sample
        if (timeout_count > cfg.timeout_limit)
        begin
            close_measurement('0, STATUS_ABORT);
        end
        else if (taken_count >= target)
        begin
            if (good_count == '0)
            begin
                close_measurement('0, STATUS_EMPTY);
            end
            else
            begin
                average = 64'(rate_sum) / 64'(good_count);
                close_measurement(FREQ_BITS'(average), STATUS_DONE);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.sample_count = SAMPLE_COUNT_RESET;
            cfg.timeout_limit = TIMEOUT_LIMIT_RESET;
            cfg.pulse_wait_limit = WAIT_LIMIT_RESET;
            rate_sum = '0;
            taken_count = '0;
            good_count = '0;
            timeout_count = '0;
            owed_results.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_index = paddr[PADDR_BITS-1:2];
                if (pwrite)
                begin
                    case (reg_index)
                        REG_SAMPLE_COUNT:  cfg.sample_count = pwdata[CNT_BITS-1:0];
                        REG_TIMEOUT_LIMIT: cfg.timeout_limit = pwdata[CNT_BITS-1:0];
                        REG_WAIT_LIMIT:    cfg.pulse_wait_limit = pwdata[LIMIT_BITS-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    reg_name = "";
                    reg_mask = PDATA_BITS'({CNT_BITS{1'b1}});
                    case (reg_index)
                        REG_SAMPLE_COUNT:
                        begin
                            reg_name = "sample_count";
                            reg_value = PDATA_BITS'(cfg.sample_count);
                        end
                        REG_TIMEOUT_LIMIT:
                        begin
                            reg_name = "timeout_limit";
                            reg_value = PDATA_BITS'(cfg.timeout_limit);
                        end
                        REG_WAIT_LIMIT:
                        begin
                            reg_name = "pulse_wait_limit";
                            reg_value = PDATA_BITS'(cfg.pulse_wait_limit);
                            reg_mask = PDATA_BITS'({LIMIT_BITS{1'b1}});
                        end
                        default: ;
                    endcase
                    if (reg_name != "" && (prdata & reg_mask) !== reg_value)
                    begin
                        $error("%s: expected %0d, got %0d", reg_name, reg_value,
                               prdata & reg_mask);
                        error_count++;
                    end
                end
            end

            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result item with no measurement pending: frequency %0d status %0d",
                           frequency, status);
                    error_count++;
                end
                else
                begin
                    head = owed_results.pop_front();
                    if (frequency !== head.frequency)
                    begin
                        $error("frequency: expected %0d, got %0d", head.frequency, frequency);
                        error_count++;
                    end
                    if (status !== head.status)
                    begin
                        $error("status: expected %0d, got %0d", head.status, status);
                        error_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                accumulate_pulse(pulse_width);
        end
        results_owed = owed_results.size();
    end

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfa_pkg::*;

    localparam int ITEM_TARGET   = 1700;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 600;
    localparam int WIDTH_MAX     = 1048575;
    localparam logic [1:0] SPARE_REG = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_BITS-1:0]  paddr;
    logic [PDATA_BITS-1:0]  pwdata;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic [WIDTH_BITS-1:0]  pulse_width;
    logic                   in_valid;
    logic                   in_ready;
    logic [FREQ_BITS-1:0]   frequency;
    logic [STATUS_BITS-1:0] status;
    logic                   out_valid;
    logic                   out_ready;

    int error_count;
    int results_owed;
    int items_sent   = 0;
    int hold_asked   = 0;
    int wait_limit_now = WIDTH_MAX;
    bit calm = 1'b0;

    pulse_frequency_averager dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pulse_width(pulse_width), .in_valid(in_valid), .in_ready(in_ready),
        .frequency(frequency), .status(status), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    pulse_freq_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pulse_width(pulse_width), .in_valid(in_valid), .in_ready(in_ready),
        .frequency(frequency), .status(status), .out_valid(out_valid),
        .out_ready(out_ready),
        .error_count(error_count), .results_owed(results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("testbench: errors");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 120);
    endfunction

    // receiver side
    initial
    begin
        int gap;
        int hold_done;
        hold_done = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (calm)
            begin
                out_ready = 1'b1;
            end
            else
            begin
                gap = idle_cycles();
                if (gap == 0)
                    out_ready = 1'b1;
                else
                begin
                    out_ready = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // called and returns just after a falling edge
    task automatic send_width(input int unsigned w);
        int gap;
        gap = calm ? 0 : idle_cycles();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pulse_width = WIDTH_BITS'(w);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input bit is_write,
                              input logic [PDATA_BITS-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = PADDR_BITS'(idx) << 2;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // junk above the register width half of the time
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        int unsigned bits;
        logic [PDATA_BITS-1:0] data;
        bits = (idx == REG_WAIT_LIMIT) ? LIMIT_BITS : CNT_BITS;
        data = value;
        if ($urandom_range(0, 1))
            data = data | ($urandom() << bits);
        if (idx == REG_WAIT_LIMIT)
            wait_limit_now = value;
        apb_access(idx, 1'b1, data);
    endtask

    task automatic read_regs();
        logic [1:0] regs[3];
        regs = '{REG_SAMPLE_COUNT, REG_TIMEOUT_LIMIT, REG_WAIT_LIMIT};
        foreach (regs[i])
            apb_access(regs[i], 1'b0, $urandom());
    endtask

    // wait for every owed result, then let any item in flight finish
    task automatic settle();
        in_valid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned corner_widths[9];
        int unsigned sc;
        int unsigned tl;
        int unsigned wl;
        int unsigned w;
        int phase;
        int count;

        corner_widths = '{1, 2, 3, WIDTH_MAX, 0, 500000, 500001, 7, 1000};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pulse_width = '0;
        in_valid = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one sample per measurement
        read_regs();
        foreach (corner_widths[i])
            send_width(corner_widths[i]);

        // abort on the last sample, then an abort on the first
        settle();
        write_reg(REG_SAMPLE_COUNT, 3);
        write_reg(REG_TIMEOUT_LIMIT, 0);
        write_reg(REG_WAIT_LIMIT, 1000);
        read_regs();
        send_width(999);
        send_width(1000);
        send_width(1001);
        send_width(0);

        // every sample timed out
        settle();
        write_reg(REG_SAMPLE_COUNT, 2);
        write_reg(REG_TIMEOUT_LIMIT, 5);
        send_width(0);
        send_width(0);

        // zero sample count behaves as one
        settle();
        write_reg(REG_SAMPLE_COUNT, 0);
        read_regs();
        send_width(250);

        // zero wait limit turns every width into a timeout
        settle();
        write_reg(REG_WAIT_LIMIT, 0);
        read_regs();
        send_width(1);

        // lowering the sample count part way through a measurement
        settle();
        write_reg(REG_WAIT_LIMIT, WIDTH_MAX);
        write_reg(REG_SAMPLE_COUNT, 5);
        send_width(10);
        send_width(20);
        send_width(30);
        settle();
        write_reg(REG_SAMPLE_COUNT, 2);
        write_reg(SPARE_REG, $urandom());
        read_regs();
        send_width(40);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            if (phase == 0)
            begin
                sc = 1;
                tl = 10;
                wl = WIDTH_MAX;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       sc = 0;
                    1:       sc = 65535;
                    2, 3, 4: sc = 1;
                    default: sc = $urandom_range(2, 12);
                endcase
                case ($urandom_range(0, 9))
                    0:       tl = 0;
                    1:       tl = 65535;
                    2:       tl = $urandom_range(0, 65535);
                    default: tl = $urandom_range(0, 6);
                endcase
                case ($urandom_range(0, 9))
                    0:       wl = 0;
                    1:       wl = 1;
                    2, 3:    wl = WIDTH_MAX;
                    4:       wl = $urandom_range(1, WIDTH_MAX);
                    default: wl = $urandom_range(20, 5000);
                endcase
            end
            write_reg(REG_SAMPLE_COUNT, sc);
            write_reg(REG_TIMEOUT_LIMIT, tl);
            write_reg(REG_WAIT_LIMIT, wl);
            read_regs();
            calm = (phase == 0) || ($urandom_range(0, 4) == 0);
            // first phase: receiver holds off so the output slot fills and input stalls
            if (phase == 0)
                hold_asked++;
            count = $urandom_range(40, 160);
            repeat (count)
            begin
                case ($urandom_range(0, 19))
                    0: w = 0;
                    1: w = (wait_limit_now < WIDTH_MAX) ?
                           $urandom_range(wait_limit_now + 1, WIDTH_MAX) : 0;
                    2: w = WIDTH_MAX;
                    3: w = $urandom() & WIDTH_MAX;
                    4, 5, 6: w = $urandom_range(1, 16);
                    default: w = $urandom_range(1, (wait_limit_now > 0) ? wait_limit_now : 1);
                endcase
                send_width(w);
            end
            phase++;
        end
        calm = 1'b0;

        settle();
        if (error_count == 0 && results_owed == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
